// File: rtl/core/wfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
package wfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Opcode nibble values of interest
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5,
    PH_SKIP    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CL_TEXT  = 2'd0,
    CL_PING  = 2'd1,
    CL_CLOSE = 2'd2,
    CL_OTHER = 2'd3
  } opclass_e;

  typedef enum logic [2:0] {
    ST_TEXT_OK  = 3'd0,
    ST_PING_OK  = 3'd1,
    ST_CLOSE    = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BAD_UTF8 = 3'd5
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  // One queue entry: an optional payload byte followed by an optional status
  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       has_status;
    status_e    status;
  } wfd_cmd_t;

endpackage

// File: rtl/core/wfd_byte_if.sv
// Input channel: one received buffer byte per word.
interface wfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// File: rtl/core/wfd_result_if.sv
// Output channel: payload bytes and end-of-frame status words.
interface wfd_result_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [2:0] frame_status;
  logic       run_last;

  modport source (output valid, output item_kind, output payload_byte,
                  output frame_status, output run_last, input ready);
  modport sink   (input valid, input item_kind, input payload_byte,
                  input frame_status, input run_last, output ready);
endinterface

// File: rtl/core/wfd_parser.sv
// Front end: header parse, unmasking and UTF-8 check, one byte per cycle while the queue has room.
module wfd_parser
  import wfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wfd_byte_if.sink    rx_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output wfd_cmd_t    cmd_o
);

  phase_e      phase_q, phase_d;
  opclass_e    opcls_q, opcls_d;
  logic        mask_q, mask_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic [1:0]  upend_q, upend_d;
  logic        uerr_q, uerr_d;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  v;
  logic [7:0]  key_byte;
  logic [6:0]  len7;
  logic        emit_pay;
  status_e     status;

  assign rx_i.ready = !queue_full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign len7       = b[6:0];

  always_comb begin
    case (midx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    opcls_d  = opcls_q;
    mask_d   = mask_q;
    hcnt_d   = hcnt_q;
    rem_d    = rem_q;
    key_d    = key_q;
    midx_d   = midx_q;
    upend_d  = upend_q;
    uerr_d   = uerr_q;
    v        = b;
    emit_pay = 1'b0;
    status   = ST_SHORT;

    if (accept) begin
      case (phase_q)
        PH_HDR1: begin
          if (opcls_q != CL_TEXT) begin
            phase_d = PH_SKIP;
          end else begin
            mask_d = b[7];
            if (len7 == LEN_EXT16) begin
              rem_d   = '0;
              hcnt_d  = 3'd1;
              phase_d = PH_EXTLEN;
            end else if (len7 == LEN_EXT64) begin
              rem_d   = '0;
              hcnt_d  = 3'd7;
              phase_d = PH_EXTLEN;
            end else begin
              rem_d = 64'(len7);
              if (b[7]) begin
                hcnt_d  = 3'd3;
                phase_d = PH_KEY;
              end else begin
                phase_d = (len7 == 7'd0) ? PH_DONE : PH_PAYLOAD;
              end
            end
          end
        end
        PH_EXTLEN: begin
          rem_d = {rem_q[55:0], b};
          if (hcnt_q == 3'd0) begin
            if (mask_q) begin
              hcnt_d  = 3'd3;
              phase_d = PH_KEY;
            end else begin
              phase_d = (rem_d == 64'd0) ? PH_DONE : PH_PAYLOAD;
            end
          end else begin
            hcnt_d = hcnt_q - 3'd1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], b};
          if (hcnt_q == 3'd0) begin
            midx_d  = 2'd0;
            phase_d = (rem_q == 64'd0) ? PH_DONE : PH_PAYLOAD;
          end else begin
            hcnt_d = hcnt_q - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          if (mask_q) begin
            v      = b ^ key_byte;
            midx_d = midx_q + 2'd1;
          end
          // lead/continuation check; error is sticky
          if (!uerr_q) begin
            if (upend_q == 2'd0) begin
              if (v[7:5] == 3'b110) upend_d = 2'd1;
              else if (v[7:4] == 4'b1110) upend_d = 2'd2;
              else if (v[7:3] == 5'b11110) upend_d = 2'd3;
              else if (v[7]) uerr_d = 1'b1;
            end else begin
              if (v[7:6] != 2'b10) uerr_d = 1'b1;
              else upend_d = upend_q - 2'd1;
            end
          end
          emit_pay = 1'b1;
          rem_d    = rem_q - 64'd1;
          if (rem_q == 64'd1) phase_d = PH_DONE;
        end
        PH_DONE, PH_SKIP: begin
        end
        default: begin
          case (b[3:0])
            OP_TEXT:          opcls_d = CL_TEXT;
            OP_PING, OP_PONG: opcls_d = CL_PING;
            OP_CLOSE:         opcls_d = CL_CLOSE;
            default:          opcls_d = CL_OTHER;
          endcase
          phase_d = PH_HDR1;
        end
      endcase

      if (phase_d == PH_SKIP) begin
        status = status_e'({1'b0, opcls_d});
      end else if (phase_d == PH_DONE) begin
        status = (uerr_d || upend_d != 2'd0) ? ST_BAD_UTF8 : ST_TEXT_OK;
      end

      // buffer end: back to the idle header state
      if (rx_i.buffer_end) begin
        phase_d = PH_HDR0;
        opcls_d = CL_TEXT;
        mask_d  = 1'b0;
        hcnt_d  = '0;
        rem_d   = '0;
        key_d   = '0;
        midx_d  = '0;
        upend_d = '0;
        uerr_d  = 1'b0;
      end
    end
  end

  assign push_o              = accept && (emit_pay || rx_i.buffer_end);
  assign cmd_o.has_payload   = emit_pay;
  assign cmd_o.payload_byte  = v;
  assign cmd_o.has_status    = rx_i.buffer_end;
  assign cmd_o.status        = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      opcls_q <= CL_TEXT;
      mask_q  <= 1'b0;
      hcnt_q  <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      midx_q  <= '0;
      upend_q <= '0;
      uerr_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      opcls_q <= opcls_d;
      mask_q  <= mask_d;
      hcnt_q  <= hcnt_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      midx_q  <= midx_d;
      upend_q <= upend_d;
      uerr_q  <= uerr_d;
    end
  end

  a_key_needs_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEY |-> mask_q)
    else $error("mask key phase without mask bit");

  a_payload_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != 64'd0)
    else $error("payload phase with zero remaining length");

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_i.buffer_end |=> phase_q == PH_HDR0 && !uerr_q && upend_q == 2'd0)
    else $error("state not cleared after buffer end");

endmodule

// File: rtl/core/wfd_queue.sv
// Short command queue between the parser and the result emitter.
module wfd_queue
  import wfd_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  wfd_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output wfd_cmd_t data_o,
  output logic     valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wfd_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/wfd_emitter.sv
// Back end: turns queue commands into result words through an output register.
module wfd_emitter
  import wfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  wfd_cmd_t    cmd_i,
  output logic        pop_o,
  wfd_result_if.source res_o
);

  logic       out_valid_q, out_valid_d;
  kind_e      kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  status_e    stat_q, stat_d;
  logic       last_q, last_d;
  // status still owed after a payload word of the same command
  logic       pend_q, pend_d;
  status_e    pend_stat_q, pend_stat_d;

  logic       load;

  assign load = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    stat_d      = stat_q;
    last_d      = last_q;
    pend_d      = pend_q;
    pend_stat_d = pend_stat_q;
    pop_o       = 1'b0;

    if (load) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_valid_d = 1'b1;
        kind_d      = KIND_STATUS;
        byte_d      = '0;
        stat_d      = pend_stat_q;
        last_d      = 1'b1;
        pend_d      = 1'b0;
      end else if (cmd_valid_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        if (cmd_i.has_payload) begin
          kind_d      = KIND_PAYLOAD;
          byte_d      = cmd_i.payload_byte;
          stat_d      = ST_TEXT_OK;
          last_d      = 1'b0;
          pend_d      = cmd_i.has_status;
          pend_stat_d = cmd_i.status;
        end else begin
          kind_d = KIND_STATUS;
          byte_d = '0;
          stat_d = cmd_i.status;
          last_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    byte_q      <= byte_d;
    stat_q      <= stat_d;
    last_q      <= last_d;
    pend_stat_q <= pend_stat_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.item_kind    = kind_q;
  assign res_o.payload_byte = byte_q;
  assign res_o.frame_status = stat_q;
  assign res_o.run_last     = last_q;

  a_pend_behind_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q && kind_q == KIND_PAYLOAD)
    else $error("owed status without a payload word ahead of it");

  a_last_on_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (last_q == (kind_q == KIND_STATUS)))
    else $error("run_last does not match word kind");

endmodule

// File: rtl/core/websocket_frame_decoder.sv
// Decodes one frame per buffer: takes one byte per cycle while the command queue has
// room and, with no output stall, returns one word per cycle; each word passes through
// the command queue and then the output register. Text payload bytes come out unmasked
// as they arrive; the buffer's final byte gives a status word, so a final byte that is
// also payload yields a payload word and then a status word. The parser keeps taking
// bytes while the command queue (QueueDepth entries) has room, so input keeps flowing
// through a short output stall; the queue depth sets how long. Payload words precede
// the status, and a consumer drops them unless the status is text ok.
module websocket_frame_decoder
  import wfd_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wfd_byte_if.sink     rx_i,
  wfd_result_if.source res_o
);

  logic     push;
  logic     full;
  wfd_cmd_t push_cmd;
  logic     pop;
  logic     head_valid;
  wfd_cmd_t head_cmd;

  wfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .queue_full_i (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  wfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .valid_o (head_valid)
  );

  wfd_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .res_o       (res_o)
  );

endmodule
